>>> design/fsd_pkg.sv
// Shared types, constants and helper functions for the sensor fusion motor drive.
// No dependencies; every other file imports this package.
package fsd_pkg;

  // Q8.16 word and field widths.
  localparam int unsigned QW     = 24;
  localparam int unsigned GW     = 16;
  localparam int unsigned S1W    = 23;
  localparam int unsigned MOTW   = 18;
  localparam int unsigned FRAC_W = 16;

  // APB register file geometry.
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // Iterative unit sizing.
  localparam int unsigned ROOT_W    = 20;  // bits of floor(sqrt(sample_one << 16))
  localparam int unsigned SQ_STEPS  = 20;  // one root bit per step
  localparam int unsigned DIV_W     = 42;  // |numerator| << 16
  localparam int unsigned DIV_STEPS = 42;  // one quotient bit per step
  localparam int unsigned CW        = 25;  // compare/subtract width
  localparam int unsigned CNT_W     = 6;

  // Shared multiplier operands and product.
  localparam int unsigned MA_W = 22;
  localparam int unsigned MB_W = 25;
  localparam int unsigned PW   = MA_W + MB_W;

  // floor(x / 3) for x < 2^21 is (x * ceil(2^21 / 3)) >> 21.
  localparam logic signed [MB_W-1:0] DIV3_RECIP = 25'sd699051;
  localparam int unsigned DIV3_SHIFT = 21;

  localparam logic signed [47:0] THREE_Q = 48'sd196608;
  localparam logic signed [QW-1:0] ONE_Q     = 24'sd65536;
  localparam logic signed [QW-1:0] NEG_ONE_Q = -24'sd65536;

  typedef logic signed [QW-1:0]   q_t;
  typedef logic signed [GW-1:0]   gain_t;
  typedef logic [S1W-1:0]         s1_t;
  typedef logic signed [MOTW-1:0] motor_t;

  typedef struct packed {
    gain_t gain_one;
    q_t    offset_one;
    gain_t gain_two;
    q_t    offset_two;
    gain_t gain_three;
    q_t    offset_three;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_GAIN_ONE     = 3'd0,
    REG_OFFSET_ONE   = 3'd1,
    REG_GAIN_TWO     = 3'd2,
    REG_OFFSET_TWO   = 3'd3,
    REG_GAIN_THREE   = 3'd4,
    REG_OFFSET_THREE = 3'd5
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQRT,
    ST_DIV3,
    ST_ROOT,
    ST_SCALE,
    ST_NUM,
    ST_DIV,
    ST_FUSE,
    ST_DONE
  } state_e;

  // Saturate a wide signed value to the Q8.16 range.
  function automatic q_t sat_q(input logic signed [47:0] v);
    logic signed [47:0] hi;
    logic signed [47:0] lo;
    hi = 48'sd8388607;
    lo = -48'sd8388608;
    if (v > hi) begin
      return 24'sh7FFFFF;
    end else if (v < lo) begin
      return 24'sh800000;
    end else begin
      return v[QW-1:0];
    end
  endfunction

endpackage

>>> design/fsd_in_if.sv
// Input channel carrying one word of three sensor samples.
// Depends on fsd_pkg for the field types.
interface fsd_in_if;
  import fsd_pkg::*;

  logic valid;
  logic ready;
  s1_t  sample_one;
  q_t   sample_two;
  q_t   sample_three;

  modport source (output valid, output sample_one, output sample_two,
                  output sample_three, input ready);
  modport sink (input valid, input sample_one, input sample_two,
                input sample_three, output ready);
endinterface

>>> design/fsd_out_if.sv
// Output channel carrying one result word of the fusion block.
// Depends on fsd_pkg for the field types.
interface fsd_out_if;
  import fsd_pkg::*;

  logic   valid;
  logic   ready;
  s1_t    root_converted;
  q_t     difference;
  q_t     scaled_one;
  q_t     scaled_two;
  q_t     scaled_three;
  q_t     fused_value;
  motor_t motor_a;
  motor_t motor_b;
  logic   divide_by_zero;

  modport source (output valid, output root_converted, output difference,
                  output scaled_one, output scaled_two, output scaled_three,
                  output fused_value, output motor_a, output motor_b,
                  output divide_by_zero, input ready);
  modport sink (input valid, input root_converted, input difference,
                input scaled_one, input scaled_two, input scaled_three,
                input fused_value, input motor_a, input motor_b,
                input divide_by_zero, output ready);
endinterface

>>> design/fsd_cfg.sv
// APB-style register file holding the three gains and three offsets.
// Depends on fsd_pkg for the register codes and the cfg_t bundle.
module fsd_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [fsd_pkg::ADDR_W-1:0] paddr,
  input  logic [fsd_pkg::DATA_W-1:0] pwdata,
  output logic [fsd_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  output fsd_pkg::cfg_t             cfg_o
);
  import fsd_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_q;

  // Register writes; out-of-range indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_one     <= 16'sd11059;
      cfg_q.offset_one   <= 24'sd65536;
      cfg_q.gain_two     <= 16'sd2867;
      cfg_q.offset_two   <= -24'sd32768;
      cfg_q.gain_three   <= 16'sd4096;
      cfg_q.offset_three <= 24'sd13107;
    end else if (wr_en) begin
      case (idx)
        REG_GAIN_ONE:     cfg_q.gain_one     <= pwdata[GW-1:0];
        REG_OFFSET_ONE:   cfg_q.offset_one   <= pwdata[QW-1:0];
        REG_GAIN_TWO:     cfg_q.gain_two     <= pwdata[GW-1:0];
        REG_OFFSET_TWO:   cfg_q.offset_two   <= pwdata[QW-1:0];
        REG_GAIN_THREE:   cfg_q.gain_three   <= pwdata[GW-1:0];
        REG_OFFSET_THREE: cfg_q.offset_three <= pwdata[QW-1:0];
        default: ;
      endcase
    end
  end

  // Read back, sign extended to the bus width.
  always_comb begin
    case (idx)
      REG_GAIN_ONE:     prdata = {{(DATA_W-GW){cfg_q.gain_one[GW-1]}}, cfg_q.gain_one};
      REG_OFFSET_ONE:   prdata = {{(DATA_W-QW){cfg_q.offset_one[QW-1]}}, cfg_q.offset_one};
      REG_GAIN_TWO:     prdata = {{(DATA_W-GW){cfg_q.gain_two[GW-1]}}, cfg_q.gain_two};
      REG_OFFSET_TWO:   prdata = {{(DATA_W-QW){cfg_q.offset_two[QW-1]}}, cfg_q.offset_two};
      REG_GAIN_THREE:   prdata = {{(DATA_W-GW){cfg_q.gain_three[GW-1]}}, cfg_q.gain_three};
      REG_OFFSET_THREE: prdata = {{(DATA_W-QW){cfg_q.offset_three[QW-1]}},
                                  cfg_q.offset_three};
      default:          prdata = '0;
    endcase
  end

endmodule

>>> design/fsd_cmpsub.sv
// Shared compare-and-subtract unit used by both the square root and the divider.
// Depends on fsd_pkg for the operand width.
module fsd_cmpsub (
  input  logic [fsd_pkg::CW-1:0] a_i,
  input  logic [fsd_pkg::CW-1:0] b_i,
  output logic                   ge_o,
  output logic [fsd_pkg::CW-1:0] diff_o
);
  import fsd_pkg::*;

  logic [CW:0] wide;

  // The borrow out of the subtraction gives the compare result.
  assign wide   = {1'b0, a_i} - {1'b0, b_i};
  assign ge_o   = ~wide[CW];
  assign diff_o = wide[CW-1:0];

endmodule

>>> design/fsd_core.sv
// Sequencer and datapath: bit-serial square root, shared multiplier for the
// scalings, bit-serial divide, and the output register. Depends on fsd_pkg,
// fsd_in_if, fsd_out_if and fsd_cmpsub.
module fsd_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  fsd_pkg::cfg_t cfg_i,
  fsd_in_if.sink        in_i,
  fsd_out_if.source     out_o
);
  import fsd_pkg::*;

  state_e state_q, state_d;

  logic [CNT_W-1:0]  cnt_q;
  logic [1:0]        scl_q;
  logic [DIV_W-1:0]  sh_q;
  logic [CW-1:0]     rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [QW-1:0]     dvs_q;
  logic              neg_q;
  logic              zero_q;
  q_t                prev_q;
  q_t                c_q;
  q_t                diff_q;
  s1_t               rconv_q;
  q_t                s1_q, s2_q, s3_q;
  q_t                fused_q;
  logic signed [PW-1:0] prod_q;

  logic   out_valid_q;
  s1_t    o_root_q;
  q_t     o_diff_q, o_s1_q, o_s2_q, o_s3_q, o_fused_q;
  motor_t o_mota_q, o_motb_q;
  logic   o_zero_q;

  logic accept, load_out, cnt_done;

  // Shared unit operands and results.
  logic [CW-1:0] cs_a, cs_b, cs_diff;
  logic          cs_ge;

  // Shared multiplier operands.
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  gain_t                  sel_gain;
  q_t                     sel_val, sel_off;
  logic signed [MB_W-1:0] sub_val;

  q_t scaled_w;
  q_t diff_w;

  logic signed [QW:0]   d13;
  logic signed [QW+2:0] num;
  logic [QW+1:0]        num_mag;
  logic                 num_neg;

  logic signed [DIV_W:0] qs;
  q_t                    fused_w;
  motor_t                motor_w;

  fsd_cmpsub u_cmpsub (
    .a_i   (cs_a),
    .b_i   (cs_b),
    .ge_o  (cs_ge),
    .diff_o(cs_diff)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid & in_i.ready;
  assign cnt_done   = (cnt_q == '0);

  // Compare/subtract operands: root trial value or divisor against the partial remainder.
  always_comb begin
    if (state_q == ST_SQRT) begin
      cs_a = {rem_q[CW-3:0], sh_q[2*ROOT_W-1 -: 2]};
      cs_b = CW'({root_q, 2'b01});
    end else begin
      cs_a = {rem_q[CW-2:0], sh_q[DIV_W-1]};
      cs_b = {1'b0, dvs_q};
    end
  end

  // Scaling operand selection by step number.
  always_comb begin
    case (scl_q)
      2'd0: begin
        sel_gain = cfg_i.gain_one;
        sel_val  = q_t'({1'b0, rconv_q});
        sel_off  = cfg_i.offset_one;
      end
      2'd1: begin
        sel_gain = cfg_i.gain_two;
        sel_val  = diff_q;
        sel_off  = cfg_i.offset_two;
      end
      default: begin
        sel_gain = cfg_i.gain_three;
        sel_val  = c_q;
        sel_off  = cfg_i.offset_three;
      end
    endcase
    sub_val = {sel_val[QW-1], sel_val} - {sel_off[QW-1], sel_off};
    if (state_q == ST_DIV3) begin
      mul_a = MA_W'({1'b0, root_q, 1'b0});
      mul_b = DIV3_RECIP;
    end else begin
      mul_a = {{(MA_W-GW){sel_gain[GW-1]}}, sel_gain};
      mul_b = sub_val;
    end
  end

  // Saturating arithmetic on the registered product and on the incoming second sample.
  always_comb begin
    scaled_w = sat_q({{13{prod_q[PW-1]}}, prod_q[PW-1:12]});
    d13      = {in_i.sample_two[QW-1], in_i.sample_two} - {prev_q[QW-1], prev_q};
    diff_w   = sat_q({{(48-QW-1){d13[QW]}}, d13});
  end

  // Numerator 3 * (s1 - s3) and its magnitude.
  logic signed [QW:0] d_s13;
  always_comb begin
    d_s13   = {s1_q[QW-1], s1_q} - {s3_q[QW-1], s3_q};
    num     = {d_s13[QW], d_s13[QW], d_s13} + {d_s13[QW], d_s13, 1'b0};
    num_neg = num[QW+2];
    num_mag = num_neg ? (QW+2)'(-num) : num[QW+1:0];
  end

  // Signed quotient, offset by three, saturated, then the motor clip.
  always_comb begin
    qs      = neg_q ? -$signed({1'b0, sh_q}) : $signed({1'b0, sh_q});
    fused_w = sat_q($signed({{(48-DIV_W-1){qs[DIV_W]}}, qs}) - THREE_Q);
    if (fused_q > ONE_Q) begin
      motor_w = MOTW'(ONE_Q);
    end else if (fused_q < NEG_ONE_Q) begin
      motor_w = MOTW'(NEG_ONE_Q);
    end else begin
      motor_w = fused_q[MOTW-1:0];
    end
  end

  // Sequencer: next state.
  always_comb begin
    state_d  = state_q;
    load_out = 1'b0;
    case (state_q)
      ST_IDLE:  if (accept) state_d = ST_SQRT;
      ST_SQRT:  if (cnt_done) state_d = ST_DIV3;
      ST_DIV3:  state_d = ST_ROOT;
      ST_ROOT:  state_d = ST_SCALE;
      ST_SCALE: if (scl_q == 2'd3) state_d = ST_NUM;
      ST_NUM:   state_d = (s2_q == '0) ? ST_FUSE : ST_DIV;
      ST_DIV:   if (cnt_done) state_d = ST_FUSE;
      ST_FUSE:  state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Previous second sample and output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= NEG_ONE_Q;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) prev_q <= in_i.sample_two;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers, stepped by the sequencer.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          sh_q   <= {{(DIV_W-S1W-FRAC_W){1'b0}}, in_i.sample_one, {FRAC_W{1'b0}}};
          rem_q  <= '0;
          root_q <= '0;
          cnt_q  <= CNT_W'(SQ_STEPS - 1);
          c_q    <= in_i.sample_three;
          diff_q <= diff_w;
        end
      end
      ST_SQRT: begin
        sh_q   <= {sh_q[DIV_W-3:0], 2'b00};
        rem_q  <= cs_ge ? cs_diff : cs_a;
        root_q <= {root_q[ROOT_W-2:0], cs_ge};
        cnt_q  <= cnt_q - 1'b1;
      end
      ST_DIV3: begin
        prod_q <= mul_a * mul_b;
      end
      ST_ROOT: begin
        rconv_q <= prod_q[DIV3_SHIFT +: S1W];
        scl_q   <= 2'd0;
      end
      ST_SCALE: begin
        if (scl_q != 2'd3) prod_q <= mul_a * mul_b;
        case (scl_q)
          2'd1:    s1_q <= scaled_w;
          2'd2:    s2_q <= scaled_w;
          2'd3:    s3_q <= scaled_w;
          default: ;
        endcase
        scl_q <= scl_q + 2'd1;
      end
      ST_NUM: begin
        zero_q <= (s2_q == '0);
        dvs_q  <= s2_q[QW-1] ? QW'(-s2_q) : s2_q;
        rem_q  <= '0;
        cnt_q  <= CNT_W'(DIV_STEPS - 1);
        if (s2_q == '0) begin
          // Divide by zero: a huge quotient saturates by the numerator sign.
          neg_q <= num_neg;
          sh_q  <= (num == '0) ? '0 : (DIV_W'(1) << 40);
        end else begin
          neg_q <= num_neg ^ s2_q[QW-1];
          sh_q  <= {num_mag, {FRAC_W{1'b0}}};
        end
      end
      ST_DIV: begin
        sh_q  <= {sh_q[DIV_W-2:0], cs_ge};
        rem_q <= cs_ge ? cs_diff : cs_a;
        cnt_q <= cnt_q - 1'b1;
      end
      ST_FUSE: begin
        fused_q <= fused_w;
      end
      ST_DONE: begin
        if (load_out) begin
          o_root_q  <= rconv_q;
          o_diff_q  <= diff_q;
          o_s1_q    <= s1_q;
          o_s2_q    <= s2_q;
          o_s3_q    <= s3_q;
          o_fused_q <= fused_q;
          o_mota_q  <= motor_w;
          o_motb_q  <= -motor_w;
          o_zero_q  <= zero_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.root_converted = o_root_q;
  assign out_o.difference     = o_diff_q;
  assign out_o.scaled_one     = o_s1_q;
  assign out_o.scaled_two     = o_s2_q;
  assign out_o.scaled_three   = o_s3_q;
  assign out_o.fused_value    = o_fused_q;
  assign out_o.motor_a        = o_mota_q;
  assign out_o.motor_b        = o_motb_q;
  assign out_o.divide_by_zero = o_zero_q;

endmodule

>>> design/three_sensor_fusion_motor_drive_top.sv
// Channel   Dir  Handshake      Word contents
// in_i      in   valid/ready    sample_one, sample_two, sample_three
// out_o     out  valid/ready    root, difference, three scaled values, fused, motors, flag
// apb       in   psel/penable   gains and offsets at byte address 4*index
//
// An item passes from acceptance to its result through the bit-serial square root,
// the divide by three and the three scalings on one shared multiplier, the
// bit-serial divide, and the setup and finish steps. With a zero scaled second
// value the divide is skipped.
// in_i.ready is high only while the sequencer is idle; the output register lets
// the next word start while a result waits, and a full output stalls only the finish.
// Reset restores the register defaults and sets the previous second sample to -1.0.
module three_sensor_fusion_motor_drive_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fsd_pkg::ADDR_W-1:0] paddr,
  input  logic [fsd_pkg::DATA_W-1:0] pwdata,
  output logic [fsd_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  fsd_in_if.sink                     in_i,
  fsd_out_if.source                  out_o
);
  import fsd_pkg::*;

  cfg_t cfg;

  // Configuration registers.
  fsd_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  // Sequencer and datapath.
  fsd_core u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg),
    .in_i  (in_i),
    .out_o (out_o)
  );

endmodule
